// ===== src/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared constants and types of the sprite frame sequencer
// Field widths, derived datapath widths, mode codes, register indexes and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int TIME_BITS  = 32;

  // fixed field widths
  localparam int MODE_W     = 3;
  localparam int FC_W       = 9;
  localparam int DUR_W      = 32;
  localparam int FF_W       = 16;
  localparam int DELTA_W    = 16;
  localparam int IDX_W      = 16;
  localparam int NUM_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // derived widths
  localparam int AW    = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;  // divisor / remainder
  localparam int FB    = $clog2(MAX_FRAMES + 1);                   // frame count
  localparam int CF_W  = $clog2(MAX_FRAMES);                       // frame number
  localparam int QW    = $clog2(MAX_FRAMES) + 2;                   // quotient (< 3 * frames)
  localparam int PW    = AW + FB;                                  // product
  localparam int DW    = (TIME_BITS > QW) ? TIME_BITS : QW;        // dividend shifter
  localparam int CNT_W = $clog2(DW + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ONCE         = 3'd0,
    MODE_ONCE_END     = 3'd1,
    MODE_LOOP         = 3'd2,
    MODE_ONCE_REV     = 3'd3,
    MODE_ONCE_END_REV = 3'd4,
    MODE_LOOP_REV     = 3'd5,
    MODE_SWING        = 3'd6,
    MODE_SWING_REV    = 3'd7
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_ON_FIRST = 3'd4;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic capture;    // take the input word
    logic eval;       // start command, or saturating time add
    logic stop;       // once mode ran out
    logic mod_load;   // set divider up for time remainder
    logic div_step;   // one restoring division step
    logic rem_to_t;   // last remainder step: wrapped time back to t
    logic mul_load;   // scale by frame count and set divider up for quotient
    logic frame_set;  // clamp / mirror quotient into current frame
    logic out_load;   // load output register
  } cmd_t;

  typedef struct packed {
    logic start;
    logic active;
    logic once_mode;
    logic t_ge_dur;
  } status_t;

endpackage

// ===== src/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer: sprite animation frame sequencer
// Start and tick words drive a frame counter over time; once, loop and swing
// modes with reversed forms; one result word per input word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_ready_o   | opcode_i, delta_ms_i
//  out     | output    | out_valid_o / out_ready_i | frame_index_o, frame_number_o, running_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Start, or tick while stopped: evaluate, then the result. Tick that ends a
//  once run: evaluate, range check, stop. Other ticks: scale, then 10 quotient
//  steps of the shared divider with the default sizes, then frame update; when
//  the time reaches the duration in loop and swing modes, a remainder through
//  the same divider comes first. A result waits in the output register; the
//  next word is taken meanwhile and its result held until the register frees.
//  Reset is asynchronous, active low; config is always ready.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic [sfs_pkg::DELTA_W-1:0]     delta_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sfs_pkg::IDX_W-1:0]       frame_index_o,
  output logic [sfs_pkg::NUM_W-1:0]       frame_number_o,
  output logic                            running_o
);

  sfs_pkg::cmd_t    cmd;
  sfs_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .delta_ms_i     (delta_ms_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .frame_index_o  (frame_index_o),
    .frame_number_o (frame_number_o),
    .running_o      (running_o)
  );

endmodule

// ===== src/sfs_dp.sv =====
// ----------------------------------------------------------------------------
// sfs_dp: sequencer datapath
// Configuration registers, animation state, a shared restoring divider used
// for the time remainder and the frame quotient, and the output register.
// ----------------------------------------------------------------------------
module sfs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             opcode_i,
  input  logic [sfs_pkg::DELTA_W-1:0]      delta_ms_i,
  input  sfs_pkg::cmd_t                    cmd_i,
  output sfs_pkg::status_t                 status_o,
  output logic [sfs_pkg::IDX_W-1:0]        frame_index_o,
  output logic [sfs_pkg::NUM_W-1:0]        frame_number_o,
  output logic                             running_o
);

  localparam int AW = sfs_pkg::AW;
  localparam int TB = sfs_pkg::TIME_BITS;
  localparam int FB = sfs_pkg::FB;
  localparam int QW = sfs_pkg::QW;
  localparam int PW = sfs_pkg::PW;
  localparam int DW = sfs_pkg::DW;
  localparam int CF_W = sfs_pkg::CF_W;
  localparam int IDX_W = sfs_pkg::IDX_W;

  // configuration
  sfs_pkg::mode_e                 mode_q;
  logic [sfs_pkg::FC_W-1:0]       fc_q;
  logic [sfs_pkg::DUR_W-1:0]      dur_q;
  logic [sfs_pkg::FF_W-1:0]       ff_q;
  logic                           rest_q;

  // animation state
  logic [TB-1:0]                  elapsed_q;
  logic [CF_W-1:0]                cur_q;
  logic                           active_q;

  // working registers
  logic                           op_q;
  logic [sfs_pkg::DELTA_W-1:0]    delta_q;
  logic [TB-1:0]                  t_q;
  logic [AW-1:0]                  rem_q;
  logic [DW-1:0]                  dvd_q;
  logic [AW-1:0]                  div_q;
  logic [QW-1:0]                  quot_q;
  logic [IDX_W-1:0]               fidx_q;
  logic [sfs_pkg::NUM_W-1:0]      fnum_q;
  logic                           run_q;

  logic [FB-1:0]                  frames;
  logic [FB-1:0]                  frames_m1;
  logic [CF_W-1:0]                last_frame;
  logic [AW-1:0]                  dur_eff;
  logic [AW-1:0]                  half;
  logic [TB:0]                    sum;
  logic [TB-1:0]                  t_sat;
  logic [AW-1:0]                  t_ext;
  logic [AW-1:0]                  t_rev;
  logic                           once_mode;
  logic                           fwd_start;
  logic                           swing;
  logic                           up;
  logic [AW-1:0]                  num;
  logic [AW-1:0]                  divisor;
  logic [PW-1:0]                  prod;
  logic [AW:0]                    shifted;
  logic [AW:0]                    diff;
  logic                           q_bit;
  logic [AW-1:0]                  rem_nx;
  logic [QW-1:0]                  qmax;
  logic [QW-1:0]                  f_clamp;
  logic [QW-1:0]                  f_fin;
  logic [IDX_W:0]                 idx_sum;
  logic [IDX_W-1:0]               fidx;

  always_comb begin
    if (fc_q == '0) begin
      frames = FB'(1);
    end else if (32'(fc_q) > 32'(sfs_pkg::MAX_FRAMES)) begin
      frames = FB'(sfs_pkg::MAX_FRAMES);
    end else begin
      frames = FB'(fc_q);
    end
  end

  assign frames_m1  = frames - FB'(1);
  assign last_frame = CF_W'(frames_m1);
  assign dur_eff    = (dur_q == '0) ? AW'(1) : AW'(dur_q);
  assign half       = ((dur_eff >> 1) == '0) ? AW'(1) : (dur_eff >> 1);

  assign sum   = (TB+1)'(elapsed_q) + (TB+1)'(delta_q);
  assign t_sat = sum[TB] ? '1 : sum[TB-1:0];
  assign t_ext = AW'(t_q);
  assign t_rev = dur_eff - t_ext - AW'(1);
  assign up    = t_ext < half;

  assign once_mode = (mode_q == sfs_pkg::MODE_ONCE) || (mode_q == sfs_pkg::MODE_ONCE_END) ||
                     (mode_q == sfs_pkg::MODE_ONCE_REV) ||
                     (mode_q == sfs_pkg::MODE_ONCE_END_REV);
  assign fwd_start = (mode_q == sfs_pkg::MODE_ONCE) || (mode_q == sfs_pkg::MODE_ONCE_END) ||
                     (mode_q == sfs_pkg::MODE_LOOP) || (mode_q == sfs_pkg::MODE_SWING);
  assign swing     = (mode_q == sfs_pkg::MODE_SWING) || (mode_q == sfs_pkg::MODE_SWING_REV);

  always_comb begin
    case (mode_q)
      sfs_pkg::MODE_ONCE, sfs_pkg::MODE_ONCE_END, sfs_pkg::MODE_LOOP: num = t_ext;
      sfs_pkg::MODE_ONCE_REV, sfs_pkg::MODE_ONCE_END_REV, sfs_pkg::MODE_LOOP_REV: num = t_rev;
      sfs_pkg::MODE_SWING, sfs_pkg::MODE_SWING_REV: num = up ? t_ext : t_rev;
      default: num = t_ext;
    endcase
  end

  assign divisor = swing ? half : dur_eff;
  assign prod    = PW'(num) * PW'(frames);

  // restoring division step, shared by remainder and quotient
  assign shifted = {rem_q, dvd_q[DW-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign q_bit   = shifted >= {1'b0, div_q};
  assign rem_nx  = q_bit ? diff[AW-1:0] : shifted[AW-1:0];

  assign qmax    = QW'(frames_m1);
  assign f_clamp = (quot_q > qmax) ? qmax : quot_q;
  assign f_fin   = (mode_q == sfs_pkg::MODE_SWING_REV) ? (qmax - f_clamp) : f_clamp;

  assign idx_sum = (IDX_W+1)'(ff_q) + (IDX_W+1)'(cur_q);
  assign fidx    = idx_sum[IDX_W] ? '1 : idx_sum[IDX_W-1:0];

  assign status_o.start     = (op_q == sfs_pkg::OP_START);
  assign status_o.active    = active_q;
  assign status_o.once_mode = once_mode;
  assign status_o.t_ge_dur  = t_ext >= dur_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sfs_pkg::MODE_ONCE;
      fc_q      <= sfs_pkg::FC_W'(1);
      dur_q     <= sfs_pkg::DUR_W'(1);
      ff_q      <= '0;
      rest_q    <= 1'b1;
      elapsed_q <= '0;
      cur_q     <= '0;
      active_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sfs_pkg::CFG_MODE:          mode_q <= sfs_pkg::mode_e'(cfg_data_i[sfs_pkg::MODE_W-1:0]);
          sfs_pkg::CFG_FRAME_COUNT:   fc_q   <= cfg_data_i[sfs_pkg::FC_W-1:0];
          sfs_pkg::CFG_DURATION:      dur_q  <= cfg_data_i[sfs_pkg::DUR_W-1:0];
          sfs_pkg::CFG_FIRST_FRAME:   ff_q   <= cfg_data_i[sfs_pkg::FF_W-1:0];
          sfs_pkg::CFG_REST_ON_FIRST: rest_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.eval && (op_q == sfs_pkg::OP_START)) begin
        active_q  <= 1'b1;
        elapsed_q <= '0;
        cur_q     <= fwd_start ? '0 : last_frame;
      end
      if (cmd_i.stop) begin
        active_q  <= 1'b0;
        elapsed_q <= '0;
        cur_q     <= rest_q ? '0 : last_frame;
      end
      if (cmd_i.mul_load) begin
        elapsed_q <= t_q;
      end
      if (cmd_i.frame_set) begin
        cur_q <= CF_W'(f_fin);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= opcode_i;
      delta_q <= delta_ms_i;
    end
    if (cmd_i.eval) begin
      t_q <= t_sat;
    end
    if (cmd_i.mod_load) begin
      rem_q <= '0;
      dvd_q <= DW'(t_q) << (DW - TB);
      div_q <= dur_eff;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_nx;
      dvd_q  <= dvd_q << 1;
      quot_q <= {quot_q[QW-2:0], q_bit};
    end
    // remainder never exceeds the time it came from
    if (cmd_i.rem_to_t) begin
      t_q <= rem_nx[TB-1:0];
    end
    // quotient is below 2^QW, so the top of the product starts as remainder
    if (cmd_i.mul_load) begin
      rem_q <= AW'(prod >> QW);
      dvd_q <= DW'(prod[QW-1:0]) << (DW - QW);
      div_q <= divisor;
    end
    if (cmd_i.out_load) begin
      fidx_q <= fidx;
      fnum_q <= sfs_pkg::NUM_W'(cur_q);
      run_q  <= active_q;
    end
  end

  assign frame_index_o  = fidx_q;
  assign frame_number_o = fnum_q;
  assign running_o      = run_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> rem_q < div_q)
    else $error("divider remainder not below divisor");

  a_frame_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.frame_set |=> cur_q <= $past(last_frame))
    else $error("frame beyond last frame");

endmodule

// ===== src/sfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfs_ctrl: sequencer controller
// Steps the datapath through evaluate and, for running ticks, remainder when
// due, scale, divide and frame update; owns the handshakes and step counter.
// ----------------------------------------------------------------------------
module sfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sfs_pkg::status_t  status_i,
  output sfs_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RANGE,
    S_MOD,
    S_MUL,
    S_DIV,
    S_FRAME,
    S_DONE
  } state_e;

  state_e                      state_q;
  logic [sfs_pkg::CNT_W-1:0]   cnt_q;
  logic                        out_valid_q;
  logic                        last_step;

  assign last_step = (cnt_q == sfs_pkg::CNT_W'(1));

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.capture   = in_valid_i;
      S_EVAL:  cmd_o.eval      = 1'b1;
      S_RANGE: begin
        cmd_o.stop     = status_i.once_mode && status_i.t_ge_dur;
        cmd_o.mod_load = !status_i.once_mode && status_i.t_ge_dur;
      end
      S_MOD: begin
        cmd_o.div_step = 1'b1;
        cmd_o.rem_to_t = last_step;
      end
      S_MUL:   cmd_o.mul_load  = 1'b1;
      S_DIV:   cmd_o.div_step  = 1'b1;
      S_FRAME: cmd_o.frame_set = 1'b1;
      S_DONE:  cmd_o.out_load  = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= (status_i.start || !status_i.active) ? S_DONE : S_RANGE;
        end
        S_RANGE: begin
          if (status_i.t_ge_dur && status_i.once_mode) begin
            state_q <= S_DONE;
          end else if (status_i.t_ge_dur) begin
            cnt_q   <= sfs_pkg::CNT_W'(sfs_pkg::TIME_BITS);
            state_q <= S_MOD;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MOD: begin
          cnt_q <= cnt_q - sfs_pkg::CNT_W'(1);
          if (last_step) state_q <= S_MUL;
        end
        S_MUL: begin
          cnt_q   <= sfs_pkg::CNT_W'(sfs_pkg::QW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q - sfs_pkg::CNT_W'(1);
          if (last_step) state_q <= S_FRAME;
        end
        S_FRAME: state_q <= S_DONE;
        S_DONE: begin
          if (cmd_o.out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD || state_q == S_DIV) |-> cnt_q != '0)
    else $error("step counter empty while dividing");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_EVAL)
    else $error("accepted word not evaluated");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule
